FILE: rtl/fcp_pkg.sv
// fcp_pkg: shared types and constants of the function call profiler.
// No dependencies; used by fcp_front, fcp_back and function_call_profiler_top.
package fcp_pkg;

    localparam logic [1:0] OP_ENTER  = 2'd0;
    localparam logic [1:0] OP_EXIT   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
    localparam int MIX_SHIFT_A = 33;
    localparam int MIX_SHIFT_B = 29;

    typedef enum logic [1:0] {
        K_ENTER = 2'd0,
        K_EXIT  = 2'd1,
        K_READ  = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] func_addr;
        logic [63:0] timestamp;
        logic [9:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [47:0] entry_addr;
        logic [63:0] entry_calls;
        logic [63:0] entry_total;
        logic [63:0] entry_self;
        logic [63:0] elapsed;
        logic [63:0] self_elapsed;
        logic        table_full;
        logic        exit_ignored;
        logic        stack_overflowed;
        logic [10:0] stack_depth;
        logic [10:0] slots_used;
    } t_out_item;

    // classified command handed from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic        addr_zero;
        logic        read_ok;
        logic [47:0] func_addr;
        logic [63:0] timestamp;
        logic [9:0]  slot_index;
    } t_cmd;

endpackage

FILE: rtl/fcp_front.sv
// fcp_front: accepts input transactions, classifies them and queues them.
// Depends on fcp_pkg.
module fcp_front #(
    parameter int TABLE_SLOTS = 1024,
    parameter int ADDR_BITS   = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fcp_pkg::t_in_item i_item,
    input  logic              i_clr_done,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output fcp_pkg::t_cmd     o_cmd
);
    localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);

    fcp_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    fcp_pkg::t_cmd cls;
    logic [63:0]   a64;
    logic          push, pop;

    always_comb begin
        a64           = {16'b0, i_item.func_addr} & AMASK;
        cls.func_addr = i_item.func_addr;
        cls.timestamp = i_item.timestamp;
        cls.slot_index = i_item.slot_index;
        cls.addr_zero = (a64 == 64'd0);
        cls.read_ok   = (32'(i_item.slot_index) < 32'(TABLE_SLOTS));
        case (i_item.opcode)
            fcp_pkg::OP_ENTER: cls.kind = fcp_pkg::K_ENTER;
            fcp_pkg::OP_EXIT:  cls.kind = fcp_pkg::K_EXIT;
            fcp_pkg::OP_READ:  cls.kind = fcp_pkg::K_READ;
            default:           cls.kind = fcp_pkg::K_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2) && i_clr_done;
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/fcp_back.sv
// fcp_back: shadow stack, hashed function table and result register.
// Depends on fcp_pkg.
module fcp_back #(
    parameter int TABLE_SLOTS = 1024,
    parameter int STACK_DEPTH = 1024,
    parameter int ADDR_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  fcp_pkg::t_cmd      i_cmd,
    output logic               o_clr_done,
    output logic               o_valid,
    input  logic               i_ready,
    output fcp_pkg::t_out_item o_item
);
    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int STW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = ADDR_BITS;
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);
    // floor(2^(32+SW) / TABLE_SLOTS): quotient estimate is exact or one low
    localparam logic [63:0] RCP64 = (64'd1 << (32 + SW)) / 64'(TABLE_SLOTS);
    localparam logic [32:0] RCP   = RCP64[32:0];

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [63:0]   calls;
        logic [63:0]   total;
        logic [63:0]   self_ns;
    } t_slot_row;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [63:0]   start;
        logic [63:0]   child;
    } t_frame_row;

    typedef enum logic [10:0] {
        S_CLR     = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_EX_DT   = 11'b000_0000_0100,
        S_EX_SELF = 11'b000_0000_1000,
        S_HASH    = 11'b000_0001_0000,
        S_HFIN    = 11'b000_0010_0000,
        S_MOD     = 11'b000_0100_0000,
        S_PRB_RD  = 11'b000_1000_0000,
        S_PRB_CHK = 11'b001_0000_0000,
        S_RD_WAIT = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_slot_row  tb_mem [TABLE_SLOTS];
    t_frame_row st_mem [STACK_DEPTH];

    t_state             r_state, n_state;
    t_slot_row          r_tb_q, r_row, tb_wd, new_row;
    t_frame_row         r_st_q, st_wd;
    logic [SW-1:0]      tb_ra, tb_wa, r_slot, r_clr_idx;
    logic [STW-1:0]     st_ra, st_wa;
    logic               tb_we, st_we;
    fcp_pkg::t_cmd      r_cmd;
    logic [AW-1:0]      r_addr, in_addr;
    logic [63:0]        a64, r_dt, r_self, r_child, r_hx, r_prod, r_acc, hmix;
    logic [1:0]         r_step;
    logic [SW-1:0]      r_rem;
    logic [64:0]        r_big;
    logic [31:0]        r_qn, mod_t, mod_e, mod_r;
    logic [5:0]         r_bitc;
    logic [CW-1:0]      r_k, r_used;
    logic [SPW-1:0]     r_sp, sp_m1;
    logic               r_ovf, r_tfull, r_exign, r_out_valid;
    logic               sp_room, slot_match;
    logic [31:0]        mul_a, mul_b, sp32, used32;
    logic [63:0]        row_a64;
    fcp_pkg::t_out_item r_out;

    function automatic logic [63:0] pre_mix(input logic [AW-1:0] a);
        logic [63:0] x;
        x = 64'(a);
        return x ^ (x >> fcp_pkg::MIX_SHIFT_A);
    endfunction

    assign a64        = {16'b0, i_cmd.func_addr} & AMASK;
    assign in_addr    = a64[AW-1:0];
    assign sp_m1      = r_sp - SPW'(1);
    assign sp_room    = (r_sp < SPW'(STACK_DEPTH));
    assign slot_match = (r_tb_q.addr == r_addr) || (r_tb_q.addr == '0);
    assign hmix       = r_acc ^ (r_acc >> fcp_pkg::MIX_SHIFT_B);

    // slot reduction: long division by 16-bit digits, top digit first
    assign mod_t = {16'(r_rem), r_acc[63:48]};
    assign mod_e = mod_t - r_qn;
    assign mod_r = (mod_e >= 32'(TABLE_SLOTS)) ? mod_e - 32'(TABLE_SLOTS) : mod_e;

    always_comb begin
        new_row.addr    = r_addr;
        new_row.calls   = r_tb_q.calls + ((r_cmd.kind == fcp_pkg::K_ENTER) ? 64'd1 : 64'd0);
        new_row.total   = r_tb_q.total + ((r_cmd.kind == fcp_pkg::K_EXIT) ? r_dt : 64'd0);
        new_row.self_ns = r_tb_q.self_ns + ((r_cmd.kind == fcp_pkg::K_EXIT) ? r_self : 64'd0);
    end

    // shared 32x32 multiplier operands: three partial products of the low 64 bits
    always_comb begin
        case (r_step)
            2'd0:    begin mul_a = r_hx[31:0];  mul_b = fcp_pkg::MIX_MUL[31:0];  end
            2'd1:    begin mul_a = r_hx[31:0];  mul_b = fcp_pkg::MIX_MUL[63:32]; end
            default: begin mul_a = r_hx[63:32]; mul_b = fcp_pkg::MIX_MUL[31:0];  end
        endcase
    end

    always_comb begin
        n_state = r_state;
        tb_we   = 1'b0;
        tb_wa   = r_slot;
        tb_wd   = new_row;
        tb_ra   = r_slot;
        st_we   = 1'b0;
        st_wa   = r_sp[STW-1:0];
        st_wd   = '{addr: in_addr, start: i_cmd.timestamp, child: 64'd0};
        st_ra   = sp_m1[STW-1:0];
        case (r_state)
            S_CLR: begin
                tb_we = 1'b1;
                tb_wa = r_clr_idx;
                tb_wd = '0;
                if (r_clr_idx == SW'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        fcp_pkg::K_ENTER: begin
                            st_we   = sp_room;
                            n_state = i_cmd.addr_zero ? S_DONE : S_HASH;
                        end
                        fcp_pkg::K_EXIT: begin
                            n_state = (r_sp == '0) ? S_DONE : S_EX_DT;
                        end
                        fcp_pkg::K_READ: begin
                            tb_ra   = SW'(32'(i_cmd.slot_index));
                            n_state = i_cmd.read_ok ? S_RD_WAIT : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EX_DT: n_state = S_EX_SELF;
            S_EX_SELF: begin
                if (r_sp != '0) begin
                    st_we = 1'b1;
                    st_wa = sp_m1[STW-1:0];
                    st_wd = '{addr: r_st_q.addr, start: r_st_q.start,
                              child: r_st_q.child + r_dt};
                end
                n_state = (r_addr == '0) ? S_DONE : S_HASH;
            end
            S_HASH: begin
                if (r_step == 2'd3) begin
                    n_state = S_HFIN;
                end
            end
            S_HFIN: n_state = IS_POW2 ? S_PRB_RD : S_MOD;
            S_MOD: begin
                if (r_step == 2'd2 && r_bitc == 6'd0) begin
                    n_state = S_PRB_RD;
                end
            end
            S_PRB_RD: n_state = S_PRB_CHK;
            S_PRB_CHK: begin
                if (slot_match) begin
                    tb_we   = 1'b1;
                    n_state = S_DONE;
                end else if (r_k == CW'(TABLE_SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PRB_RD;
                end
            end
            S_RD_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            tb_mem[tb_wa] <= tb_wd;
        end
        r_tb_q <= tb_mem[tb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        r_st_q <= st_mem[st_ra];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd   <= i_cmd;
                    r_addr  <= in_addr;
                    r_dt    <= 64'd0;
                    r_self  <= 64'd0;
                    r_row   <= '0;
                    r_tfull <= (i_cmd.kind == fcp_pkg::K_ENTER) && i_cmd.addr_zero;
                    r_exign <= (i_cmd.kind == fcp_pkg::K_EXIT) && (r_sp == '0);
                    r_hx    <= pre_mix(in_addr);
                    r_step  <= 2'd0;
                    r_k     <= '0;
                end
            end
            S_EX_DT: begin
                r_dt    <= r_cmd.timestamp - r_st_q.start;
                r_child <= r_st_q.child;
                r_addr  <= r_st_q.addr;
            end
            S_EX_SELF: begin
                r_self  <= (r_child > r_dt) ? 64'd0 : r_dt - r_child;
                r_tfull <= (r_addr == '0);
                r_hx    <= pre_mix(r_addr);
                r_step  <= 2'd0;
            end
            S_HASH: begin
                r_prod <= 64'(mul_a) * 64'(mul_b);
                r_step <= r_step + 2'd1;
                if (r_step == 2'd1) begin
                    r_acc <= r_prod;
                end else if (r_step != 2'd0) begin
                    r_acc <= r_acc + {r_prod[31:0], 32'b0};
                end
            end
            S_HFIN: begin
                r_acc  <= hmix;
                r_slot <= hmix[SW-1:0];
                r_rem  <= '0;
                r_bitc <= 6'd3;
                r_step <= 2'd0;
            end
            // per digit: reciprocal multiply, back-multiply, compare-subtract
            S_MOD: begin
                case (r_step)
                    2'd0: begin
                        r_big  <= 65'(mod_t) * 65'(RCP);
                        r_step <= 2'd1;
                    end
                    2'd1: begin
                        r_qn   <= 32'(r_big >> (32 + SW)) * 32'(TABLE_SLOTS);
                        r_step <= 2'd2;
                    end
                    default: begin
                        r_rem  <= mod_r[SW-1:0];
                        r_acc  <= r_acc << 16;
                        r_step <= 2'd0;
                        r_bitc <= r_bitc - 6'd1;
                        if (r_bitc == 6'd0) begin
                            r_slot <= mod_r[SW-1:0];
                        end
                    end
                endcase
            end
            S_PRB_CHK: begin
                if (slot_match) begin
                    r_row <= new_row;
                end else begin
                    r_k    <= r_k + CW'(1);
                    r_slot <= (r_slot == SW'(TABLE_SLOTS - 1)) ? '0 : r_slot + SW'(1);
                    if (r_k == CW'(TABLE_SLOTS - 1)) begin
                        r_tfull <= 1'b1;
                    end
                end
            end
            S_RD_WAIT: r_row <= r_tb_q;
            default: ;
        endcase
    end

    assign sp32    = 32'(r_sp);
    assign used32  = 32'(r_used);
    assign row_a64 = 64'(r_row.addr);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_sp        <= '0;
            r_ovf       <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + SW'(1);
            end
            if (r_state == S_IDLE && i_cmd_valid) begin
                if (i_cmd.kind == fcp_pkg::K_ENTER) begin
                    if (sp_room) begin
                        r_sp <= r_sp + SPW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end else if (i_cmd.kind == fcp_pkg::K_EXIT && r_sp != '0) begin
                    r_sp <= sp_m1;
                end
            end
            if (r_state == S_PRB_CHK && slot_match && r_tb_q.addr == '0) begin
                r_used <= r_used + CW'(1);
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out.entry_addr       <= row_a64[47:0];
            r_out.entry_calls      <= r_row.calls;
            r_out.entry_total      <= r_row.total;
            r_out.entry_self       <= r_row.self_ns;
            r_out.elapsed          <= r_dt;
            r_out.self_elapsed     <= r_self;
            r_out.table_full       <= r_tfull;
            r_out.exit_ignored     <= r_exign;
            r_out.stack_overflowed <= r_ovf;
            r_out.stack_depth      <= sp32[10:0];
            r_out.slots_used       <= used32[10:0];
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_clr_done  = (r_state != S_CLR);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("shadow stack pointer past depth");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_SLOTS))
        else $error("used slot count past table size");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    a_ovf_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> r_sp == SPW'(STACK_DEPTH))
        else $error("overflow set with room on the stack");

    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> !(r_state == S_DONE))
        else $error("transaction finished during table clear");

endmodule

FILE: rtl/function_call_profiler_top.sv
// function_call_profiler_top: top level of the function call profiler.
// Depends on fcp_pkg, fcp_front and fcp_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  input   | in        | i_valid / o_ready  | i_item (fcp_pkg::t_in_item)
//  result  | out       | o_valid / i_ready  | o_item (fcp_pkg::t_out_item)
//
// Paths to o_valid with an idle back end: a read goes through a table read (an index
//   past the table goes straight to the result); enter hashes and probes; exit reads
//   the frame, works out self time, then hashes and probes; exit of a zero-address frame
//   skips the hash and probe; enter of address zero, empty-stack exit and unused opcode
//   go straight to the result. The hash runs on one shared 32x32 multiplier; with a non
//   power-of-two TABLE_SLOTS the slot reduction works on four 16-bit digits, each by
//   reciprocal multiply, back-multiply and compare-subtract. Each probe is one table read plus a compare.
// Reset: synchronous, active low. After reset the table is cleared one
//   slot a cycle and o_ready stays low until done.
// Stalls: a two-entry queue takes transactions while the back end works;
//   the result register holds one transaction while i_ready is low.
module function_call_profiler_top #(
    parameter int TABLE_SLOTS = 1024,
    parameter int STACK_DEPTH = 1024,
    parameter int ADDR_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fcp_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output fcp_pkg::t_out_item o_item
);
    logic          cmd_valid, cmd_ready, clr_done;
    fcp_pkg::t_cmd cmd;

    // front: decode opcode, mask address, range-check the read index
    fcp_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_clr_done  (clr_done),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back: shadow stack, hash, linear probe, counters, result register
    fcp_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_clr_done  (clr_done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule
